@@ hw/rtl/ftgq_pkg.sv @@
// ----------------------------------------------------------------------------
// Filmic tone map package
// Shared widths, curve coefficients, payload types and the gamma threshold
// function used by the filmic tone map, gamma and quantize block.
// ----------------------------------------------------------------------------
package ftgq_pkg;

    localparam int SAMPLE_W            = 32;
    localparam int GAIN_W              = 16;
    localparam int CODE_W              = 8;
    localparam int GAIN_FRAC           = 8;
    localparam int CURVE_FRAC_BITS_DEF = 12;
    localparam int INPUT_FRAC_BITS_DEF = 16;

    // Working value x has 16 fraction bits and saturates at 8.0.
    localparam int WORK_FRAC = 16;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int X_W       = 20;
    localparam int T_W       = 21;
    localparam int COEF_W    = 18;
    localparam int TERM_W    = X_W + T_W;

    localparam logic [COEF_W-1:0] COEF_A         = 18'd164495;
    localparam logic [COEF_W-1:0] COEF_C         = 18'd159252;
    localparam logic [T_W-1:0]    COEF_B         = 21'd1966;
    localparam logic [T_W-1:0]    COEF_D         = 21'd38666;
    localparam logic [TERM_W-1:0] COEF_E_SHIFTED = TERM_W'(9175) << WORK_FRAC;
    localparam logic [X_W-1:0]    X_LIMIT        = X_W'(8) << WORK_FRAC;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    // Gamma table: code k is reached once i^5 * 510^11 >= (2k-1)^11 * 2^(5C).
    localparam int CODE_LEVELS   = 1 << CODE_W;
    localparam int GAMMA_IDX_W   = 17;
    localparam int WIDE_W        = 192;
    localparam int GAMMA_NUM_EXP = 5;
    localparam int GAMMA_DEN_EXP = 11;
    localparam int GAMMA_SCALE   = 510;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0]   gain_t;
    typedef logic [CODE_W-1:0]   code_t;

    // Pipeline control handed to each stepped unit.
    typedef struct packed {
        logic advance;
        logic valid;
    } stage_ctl_t;

    // Smallest curve index that maps to code k or above.
    function automatic logic [GAMMA_IDX_W-1:0] gamma_threshold(
        input int unsigned k,
        input int unsigned cfb
    );
        logic [WIDE_W-1:0]      rhs;
        logic [WIDE_W-1:0]      lhs;
        logic [GAMMA_IDX_W-1:0] lo;
        logic [GAMMA_IDX_W-1:0] hi;
        logic [GAMMA_IDX_W-1:0] mid;
        logic [GAMMA_IDX_W:0]   sum;
        int unsigned            j;
        int unsigned            it;
        lo  = '0;
        hi  = GAMMA_IDX_W'(1) << cfb;
        rhs = WIDE_W'(1);
        if (k != 0) begin
            for (j = 0; j < GAMMA_DEN_EXP; j++) begin
                rhs = rhs * WIDE_W'(2 * k - 1);
            end
            rhs = rhs << (GAMMA_NUM_EXP * cfb);
            for (it = 0; it <= GAMMA_IDX_W; it++) begin
                if (lo < hi) begin
                    sum = {1'b0, lo} + {1'b0, hi};
                    mid = sum[GAMMA_IDX_W:1];
                    lhs = WIDE_W'(1);
                    for (j = 0; j < GAMMA_NUM_EXP; j++) begin
                        lhs = lhs * WIDE_W'(mid);
                    end
                    for (j = 0; j < GAMMA_DEN_EXP; j++) begin
                        lhs = lhs * WIDE_W'(GAMMA_SCALE);
                    end
                    if (lhs >= rhs) begin
                        hi = mid;
                    end else begin
                        lo = mid + GAMMA_IDX_W'(1);
                    end
                end
            end
        end
        return lo;
    endfunction

endpackage

@@ hw/rtl/ftgq_channels.sv @@
// ----------------------------------------------------------------------------
// Filmic tone map channels
// Valid/ready channel interfaces for samples, display codes and the exposure
// register write port.
// ----------------------------------------------------------------------------
interface ftgq_sample_if;
    import ftgq_pkg::*;

    logic    valid;
    logic    ready;
    sample_t linear_sample;

    modport source (output valid, output linear_sample, input ready);
    modport sink (input valid, input linear_sample, output ready);
endinterface

interface ftgq_code_if;
    import ftgq_pkg::*;

    logic  valid;
    logic  ready;
    code_t display_code;

    modport source (output valid, output display_code, input ready);
    modport sink (input valid, input display_code, output ready);
endinterface

interface ftgq_gain_if;
    import ftgq_pkg::*;

    logic  valid;
    logic  ready;
    gain_t exposure_gain;

    modport source (output valid, output exposure_gain, input ready);
    modport sink (input valid, input exposure_gain, output ready);
endinterface

@@ hw/rtl/ftgq_divider.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per register stage, most significant bit first.
// ----------------------------------------------------------------------------
module ftgq_divider #(
    parameter int DIVIDEND_W = 54,
    parameter int DIVISOR_W  = 41,
    parameter int QUOT_W     = 14
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ftgq_pkg::stage_ctl_t   ctl,
    input  logic [DIVIDEND_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]   divisor,
    output logic                   out_valid,
    output logic [QUOT_W-1:0]      quotient
);
    import ftgq_pkg::*;

    // The caller guarantees dividend < divisor * 2^QUOT_W.
    logic [DIVIDEND_W-1:0] rem_reg  [QUOT_W-1];
    logic [DIVISOR_W-1:0]  dsor_reg [QUOT_W-1];
    logic [QUOT_W-1:0]     q_reg    [QUOT_W];
    logic                  v_reg    [QUOT_W];

    for (genvar s = 0; s < QUOT_W; s++) begin : g_step
        localparam int BIT = QUOT_W - 1 - s;

        logic [DIVIDEND_W-1:0] rem_in;
        logic [DIVIDEND_W-1:0] trial;
        logic [DIVIDEND_W-1:0] rem_next;
        logic [DIVISOR_W-1:0]  dsor_in;
        logic [QUOT_W-1:0]     q_in;
        logic [QUOT_W-1:0]     q_next;
        logic                  v_in;
        logic                  fits;

        if (s == 0) begin : g_head
            assign rem_in  = dividend;
            assign dsor_in = divisor;
            assign q_in    = '0;
            assign v_in    = ctl.valid;
        end else begin : g_tail
            assign rem_in  = rem_reg[s-1];
            assign dsor_in = dsor_reg[s-1];
            assign q_in    = q_reg[s-1];
            assign v_in    = v_reg[s-1];
        end

        assign trial    = DIVIDEND_W'(dsor_in) << BIT;
        assign fits     = rem_in >= trial;
        assign rem_next = fits ? rem_in - trial : rem_in;
        assign q_next   = q_in | (QUOT_W'(fits) << BIT);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (ctl.advance)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.advance)
            begin
                q_reg[s] <= q_next;
            end
        end

        if (s < QUOT_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ctl.advance)
                begin
                    rem_reg[s]  <= rem_next;
                    dsor_reg[s] <= dsor_in;
                end
            end
        end
    end

    assign out_valid = v_reg[QUOT_W-1];
    assign quotient  = q_reg[QUOT_W-1];

endmodule

@@ hw/rtl/ftgq_gamma.sv @@
// ----------------------------------------------------------------------------
// Gamma encoder
// Maps a clamped curve index to its 8-bit gamma 1/2.2 code by a pipelined
// search over the code thresholds, one code bit per register stage.
// ----------------------------------------------------------------------------
module ftgq_gamma #(
    parameter int CURVE_FRAC_BITS = ftgq_pkg::CURVE_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ftgq_pkg::stage_ctl_t       ctl,
    input  logic [CURVE_FRAC_BITS:0]   idx,
    output logic                       out_valid,
    output ftgq_pkg::code_t            code
);
    import ftgq_pkg::*;

    localparam int IDX_W = CURVE_FRAC_BITS + 1;

    // Threshold k is the first index whose code is k or more; codes rise
    // monotonically, so the code is found bit by bit.
    logic [IDX_W-1:0] thr [CODE_LEVELS];

    for (genvar k = 0; k < CODE_LEVELS; k++) begin : g_thr
        localparam logic [GAMMA_IDX_W-1:0] THR_FULL = gamma_threshold(k, CURVE_FRAC_BITS);
        assign thr[k] = THR_FULL[IDX_W-1:0];
    end

    logic [IDX_W-1:0] idx_reg  [CODE_W-1];
    code_t            code_reg [CODE_W];
    logic             v_reg    [CODE_W];

    for (genvar s = 0; s < CODE_W; s++) begin : g_step
        localparam int BIT = CODE_W - 1 - s;

        logic [IDX_W-1:0] idx_in;
        code_t            code_in;
        code_t            cand;
        code_t            code_next;
        logic             v_in;

        if (s == 0) begin : g_head
            assign idx_in  = idx;
            assign code_in = '0;
            assign v_in    = ctl.valid;
        end else begin : g_tail
            assign idx_in  = idx_reg[s-1];
            assign code_in = code_reg[s-1];
            assign v_in    = v_reg[s-1];
        end

        assign cand      = code_in | (CODE_W'(1) << BIT);
        assign code_next = (idx_in >= thr[cand]) ? cand : code_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (ctl.advance)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.advance)
            begin
                code_reg[s] <= code_next;
            end
        end

        if (s < CODE_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ctl.advance)
                begin
                    idx_reg[s] <= idx_in;
                end
            end
        end
    end

    assign out_valid = v_reg[CODE_W-1];
    assign code      = code_reg[CODE_W-1];

endmodule

@@ hw/rtl/filmic_tonemap_gamma_quantize_unit.sv @@
// ----------------------------------------------------------------------------
// Filmic tone map, gamma and quantize unit
// Turns linear 16.16 radiance samples into gamma-encoded 8-bit codes.
// ----------------------------------------------------------------------------
// Usage:
//   samples   carries one linear colour channel sample per transfer.
//   codes     returns one display code per sample, in input order.
//   gain_cfg  writes the 8.8 exposure gain; it is always ready and should
//             only be written while no sample is in flight.
// Throughput is one sample per clock while the receiver keeps up. The exposure
// multiply, the curve terms, a divider that resolves one quotient bit per stage
// and a gamma search that resolves one code bit per stage are all fully
// pipelined. Reset empties the pipeline and sets the gain to 1.0.
// When the receiver stalls, the waiting code sits in the output register and
// one more code fits in a spare register; once the spare is filled the whole
// pipeline holds and samples.ready drops, without losing or repeating items.
// ----------------------------------------------------------------------------
module filmic_tonemap_gamma_quantize_unit #(
    parameter int CURVE_FRAC_BITS = ftgq_pkg::CURVE_FRAC_BITS_DEF,
    parameter int INPUT_FRAC_BITS = ftgq_pkg::INPUT_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ftgq_sample_if.sink samples,
    ftgq_code_if.source codes,
    ftgq_gain_if.sink   gain_cfg
);
    import ftgq_pkg::*;

    localparam int PROD_SHIFT = INPUT_FRAC_BITS - GAIN_FRAC;
    localparam int IDX_W      = CURVE_FRAC_BITS + 1;
    localparam int QUOT_W     = CURVE_FRAC_BITS + 2;
    localparam int DIVIDEND_W = TERM_W + CURVE_FRAC_BITS + 1;
    localparam int AP_W       = COEF_W + X_W;
    localparam logic [QUOT_W-1:0] Q_LIMIT = QUOT_W'(1) << CURVE_FRAC_BITS;

    // Exposure register.
    gain_t gain_reg;

    assign gain_cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (gain_cfg.valid)
        begin
            gain_reg <= gain_cfg.exposure_gain;
        end
    end

    // The whole pipeline moves together unless the output spare is occupied.
    logic       advance;
    logic       spare_valid_reg;

    assign advance       = !spare_valid_reg;
    assign samples.ready = advance;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, vc_reg;

    logic [PROD_W-1:0]     prod_reg,     prod_next;
    logic [PROD_W-1:0]     prod_shifted;
    logic [X_W-1:0]        x_reg,        x_next;
    logic [AP_W-1:0]       ap_reg,       ap_next;
    logic [AP_W-1:0]       cp_reg,       cp_next;
    logic [X_W-1:0]        x3_reg;
    logic [T_W-1:0]        tn_reg,       tn_next;
    logic [T_W-1:0]        td_reg,       td_next;
    logic [X_W-1:0]        x4_reg;
    logic [TERM_W-1:0]     num_reg,      num_next;
    logic [TERM_W-1:0]     dx_reg,       dx_next;
    logic [TERM_W-1:0]     num6_reg;
    logic [TERM_W-1:0]     den_reg,      den_next;
    logic [DIVIDEND_W-1:0] dividend_reg, dividend_next;
    logic [TERM_W-1:0]     divisor_reg;
    logic [IDX_W-1:0]      idx_reg,      idx_next;

    logic                  div_valid;
    logic [QUOT_W-1:0]     quotient;
    logic                  gamma_valid;
    code_t                 gamma_code;

    always_comb
    begin
        prod_next     = samples.linear_sample * gain_reg;
        prod_shifted  = prod_reg >> PROD_SHIFT;
        x_next        = (prod_shifted > PROD_W'(X_LIMIT)) ? X_LIMIT : X_W'(prod_shifted);
        ap_next       = COEF_A * x_reg;
        cp_next       = COEF_C * x_reg;
        tn_next       = T_W'(ap_reg >> WORK_FRAC) + COEF_B;
        td_next       = T_W'(cp_reg >> WORK_FRAC) + COEF_D;
        num_next      = TERM_W'(x4_reg) * TERM_W'(tn_reg);
        dx_next       = TERM_W'(x4_reg) * TERM_W'(td_reg);
        den_next      = dx_reg + COEF_E_SHIFTED;
        // Adding half the divisor rounds the quotient to nearest.
        dividend_next = (DIVIDEND_W'(num6_reg) << CURVE_FRAC_BITS)
                        + DIVIDEND_W'(den_reg >> 1);
        idx_next      = (quotient > Q_LIMIT) ? IDX_W'(Q_LIMIT) : IDX_W'(quotient);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= samples.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            vc_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg     <= prod_next;
            x_reg        <= x_next;
            ap_reg       <= ap_next;
            cp_reg       <= cp_next;
            x3_reg       <= x_reg;
            tn_reg       <= tn_next;
            td_reg       <= td_next;
            x4_reg       <= x3_reg;
            num_reg      <= num_next;
            dx_reg       <= dx_next;
            num6_reg     <= num_reg;
            den_reg      <= den_next;
            dividend_reg <= dividend_next;
            divisor_reg  <= den_reg;
            idx_reg      <= idx_next;
        end
    end

    ftgq_divider #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (TERM_W),
        .QUOT_W     (QUOT_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       ('{advance: advance, valid: v7_reg}),
        .dividend  (dividend_reg),
        .divisor   (divisor_reg),
        .out_valid (div_valid),
        .quotient  (quotient)
    );

    ftgq_gamma #(
        .CURVE_FRAC_BITS (CURVE_FRAC_BITS)
    ) u_gamma (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       ('{advance: advance, valid: vc_reg}),
        .idx       (idx_reg),
        .out_valid (gamma_valid),
        .code      (gamma_code)
    );

    // Output register with one spare entry.
    logic  head_valid_reg, head_valid_next;
    logic  spare_valid_next;
    code_t head_code_reg,  head_code_next;
    code_t spare_code_reg, spare_code_next;
    logic  pop;
    logic  push;

    always_comb
    begin
        pop              = head_valid_reg && codes.ready;
        push             = advance && gamma_valid;
        head_valid_next  = head_valid_reg;
        spare_valid_next = spare_valid_reg;
        head_code_next   = head_code_reg;
        spare_code_next  = spare_code_reg;
        if (pop)
        begin
            if (spare_valid_reg)
            begin
                head_code_next   = spare_code_reg;
                spare_valid_next = 1'b0;
            end
            else
            begin
                head_valid_next = push;
                head_code_next  = gamma_code;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                spare_valid_next = 1'b1;
                spare_code_next  = gamma_code;
            end
            else
            begin
                head_valid_next = 1'b1;
                head_code_next  = gamma_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg  <= head_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_code_reg  <= head_code_next;
        spare_code_reg <= spare_code_next;
    end

    assign codes.valid        = head_valid_reg;
    assign codes.display_code = head_code_reg;

endmodule

@@ hw/rtl/ftgq_checker.sv @@
// ----------------------------------------------------------------------------
// Filmic tone map port checker
// Watches the top-level channels for invented results, for codes withdrawn or
// changed while stalled and for stalls that no output back-pressure explains.
// ----------------------------------------------------------------------------
module ftgq_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input ftgq_pkg::code_t out_code
);
    import ftgq_pkg::*;

    localparam int OUTSTANDING_W = 8;

    logic [OUTSTANDING_W-1:0] outstanding_reg, outstanding_next;
    logic                     in_xfer;
    logic                     out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        outstanding_next = outstanding_reg + OUTSTANDING_W'(in_xfer)
                           - OUTSTANDING_W'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A code is only offered for a sample that has been taken and not yet returned.
    a_no_invented_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outstanding_reg != '0)
        else $error("display code offered with no sample outstanding");

    // The input only stalls after a code has waited at the output.
    a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

    a_code_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("display code withdrawn before transfer");

    a_code_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_code))
        else $error("display code changed while stalled");

endmodule

bind filmic_tonemap_gamma_quantize_unit ftgq_checker u_ftgq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (codes.valid),
    .out_ready (codes.ready),
    .out_code  (codes.display_code)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Filmic tone map unit testbench
// Drives linear samples through the tone map, gamma and quantize unit under
// several exposure settings and handshake idling patterns. Every display code
// is checked against a listed code or a bit-exact model of curve and gamma.
// ----------------------------------------------------------------------------
module tb_top;
    import ftgq_pkg::*;

    localparam int CURVE_BITS = 12;
    localparam int INPUT_BITS = 16;

    // Curve coefficients at 16 fraction bits, rounded to nearest.
    localparam longint unsigned K_NUM_SQ  = 164495;
    localparam longint unsigned K_NUM_LIN = 1966;
    localparam longint unsigned K_DEN_SQ  = 159252;
    localparam longint unsigned K_DEN_LIN = 38666;
    localparam longint unsigned K_DEN_OFS = 9175;
    localparam longint unsigned X_SAT     = 64'd8 << 16;
    localparam longint unsigned CURVE_ONE = 64'd1 << CURVE_BITS;

    localparam int TAIL_CYCLES  = CURVE_BITS + 30;
    localparam int PHASE_ITEMS  = 125;
    localparam int PHASE_COUNT  = 8;
    localparam int HOLD_AT_ITEM = 60;

    typedef struct packed {
        gain_t   gain;
        sample_t sample;
        logic    code_known;
        code_t   code;
    } probe_t;

    logic clk;
    logic rst_n;

    ftgq_sample_if sample_ch ();
    ftgq_code_if   code_ch ();
    ftgq_gain_if   gain_ch ();

    filmic_tonemap_gamma_quantize_unit #(
        .CURVE_FRAC_BITS(CURVE_BITS),
        .INPUT_FRAC_BITS(INPUT_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (sample_ch),
        .codes    (code_ch),
        .gain_cfg (gain_ch)
    );

    gain_t  exposure;
    code_t  pending_codes[$];
    probe_t probes[$];
    int     send_idle_pct;
    int     recv_stall_pct;
    int     failures = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1000000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Largest code k whose half-step threshold the curve index reaches, decided
    // exactly: i^5 * 510^11 >= (2k-1)^11 * 2^(5*CURVE_BITS).
    function automatic code_t gamma_byte(logic [16:0] idx);
        logic [191:0] scaled_idx;
        logic [191:0] bound;
        int           lo;
        int           hi;
        int           mid;
        int           j;
        scaled_idx = 192'd1;
        for (j = 0; j < 5; j++)
        begin
            scaled_idx = scaled_idx * 192'(idx);
        end
        for (j = 0; j < 11; j++)
        begin
            scaled_idx = scaled_idx * 192'd510;
        end
        lo = 0;
        hi = 255;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            bound = 192'd1;
            for (j = 0; j < 11; j++)
            begin
                bound = bound * 192'(2 * mid - 1);
            end
            bound = bound << (5 * CURVE_BITS);
            if (scaled_idx >= bound)
                lo = mid;
            else
                hi = mid - 1;
        end
        return code_t'(lo);
    endfunction

    function automatic code_t tonemap_code(sample_t s, gain_t g);
        logic [63:0] x;
        logic [63:0] lin_num;
        logic [63:0] lin_den;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        x = (64'(s) * 64'(g)) >> (INPUT_BITS - 8);
        if (x > X_SAT)
            x = X_SAT;
        lin_num = ((K_NUM_SQ * x) >> 16) + K_NUM_LIN;
        lin_den = ((K_DEN_SQ * x) >> 16) + K_DEN_LIN;
        num = x * lin_num;
        den = x * lin_den + (K_DEN_OFS << 16);
        q = ((num << CURVE_BITS) + den / 2) / den;
        if (q > CURVE_ONE)
            q = CURVE_ONE;
        return gamma_byte(q[16:0]);
    endfunction

    // Half the samples (all of them at zero gain) are log-uniform over the whole
    // range; the rest aim at the curve's working range for the current exposure.
    function automatic sample_t random_sample(gain_t g);
        int          w;
        logic [63:0] target;
        if (g == '0 || $urandom_range(0, 1) == 0)
        begin
            w = $urandom_range(0, 32);
            if (w == 0)
                return '0;
            return sample_t'({32'b0, $urandom} & ((64'd1 << w) - 64'd1));
        end
        target = 64'($urandom_range(0, 9 << 16)) << 8;
        return sample_t'(target / 64'(g) + 64'($urandom_range(0, 3)));
    endfunction

    task automatic add_probe(gain_t g, sample_t s, logic known, code_t c);
        probe_t p;
        p.gain       = g;
        p.sample     = s;
        p.code_known = known;
        p.code       = c;
        probes.insert(probes.size(), p);
    endtask

    task automatic wait_drained();
        while (pending_codes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_gain(gain_t g);
        gain_ch.valid         <= 1'b1;
        gain_ch.exposure_gain <= g;
        do
            @(posedge clk);
        while (!gain_ch.ready);
        gain_ch.valid <= 1'b0;
        exposure = g;
    endtask

    // Leaves valid high after the transfer; the next call or the caller
    // lowers it, so valid is assigned once per time step.
    task automatic send_sample(sample_t s, code_t code_due);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.linear_sample <= s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pending_codes.insert(pending_codes.size(), code_due);
    endtask

    always @(posedge clk)
    begin
        code_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && code_ch.valid && code_ch.ready)
        begin
            if (pending_codes.size() == 0)
            begin
                $display("%0t: display_code with none expected, actual %0d",
                         $time, code_ch.display_code);
                failures++;
            end
            else
            begin
                if (code_ch.display_code !== pending_codes[0])
                begin
                    $display("%0t: display_code expected %0d, actual %0d",
                             $time, pending_codes[0], code_ch.display_code);
                    failures++;
                end
                void'(pending_codes.pop_front());
            end
        end
    end

    initial
    begin
        probe_t p;
        gain_t  phase_gain;
        int     ph;
        int     n;

        send_idle_pct           = 0;
        recv_stall_pct          = 0;
        exposure                = GAIN_RESET;
        rst_n                   <= 1'b0;
        sample_ch.valid         <= 1'b0;
        sample_ch.linear_sample <= '0;
        gain_ch.valid           <= 1'b0;
        gain_ch.exposure_gain   <= '0;

        // Reset exposure of 1.0 first, then zero, full scale, tiny and 128.0 gains.
        add_probe(16'd256, 32'h0000_0000, 1'b1, 8'd0);
        add_probe(16'd256, 32'h0000_0001, 1'b0, 8'd0);
        add_probe(16'd256, 32'h0000_0100, 1'b0, 8'd0);
        add_probe(16'd256, 32'h0000_FFFF, 1'b0, 8'd0);
        add_probe(16'd256, 32'h0001_0000, 1'b0, 8'd0);
        add_probe(16'd256, 32'h0007_4000, 1'b0, 8'd0);
        add_probe(16'd256, 32'h0007_8000, 1'b0, 8'd0);
        add_probe(16'd256, 32'h0008_0000, 1'b1, 8'd255);
        add_probe(16'd256, 32'h0010_0000, 1'b1, 8'd255);
        add_probe(16'd256, 32'h5555_5555, 1'b1, 8'd255);
        add_probe(16'd256, 32'hAAAA_AAAA, 1'b1, 8'd255);
        add_probe(16'd256, 32'hFFFF_FFFF, 1'b1, 8'd255);
        add_probe(16'd0, 32'hFFFF_FFFF, 1'b1, 8'd0);
        add_probe(16'd0, 32'h1234_5678, 1'b1, 8'd0);
        add_probe(16'd0, 32'h0000_0000, 1'b1, 8'd0);
        add_probe(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'd255);
        add_probe(16'hFFFF, 32'h0000_0001, 1'b0, 8'd0);
        add_probe(16'hFFFF, 32'h0000_0200, 1'b0, 8'd0);
        add_probe(16'd1, 32'hFFFF_FFFF, 1'b1, 8'd255);
        add_probe(16'd1, 32'h0080_0000, 1'b0, 8'd0);
        add_probe(16'd1, 32'h00FF_FFFF, 1'b0, 8'd0);
        add_probe(16'h8000, 32'h0000_1000, 1'b1, 8'd255);
        add_probe(16'h8000, 32'h0000_0001, 1'b0, 8'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
        begin
            p = probes[i];
            if (p.gain != exposure)
            begin
                sample_ch.valid <= 1'b0;
                wait_drained();
                write_gain(p.gain);
            end
            send_sample(p.sample, p.code_known ? p.code : tonemap_code(p.sample, exposure));
        end
        sample_ch.valid <= 1'b0;

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:       phase_gain = 16'd256;
                1:       phase_gain = 16'hFFFF;
                4:       phase_gain = 16'd1;
                5:       phase_gain = 16'd0;
                7:       phase_gain = 16'h0080;
                default: phase_gain = gain_t'($urandom_range(0, 65535));
            endcase
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default:
                begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            wait_drained();
            write_gain(phase_gain);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                p.sample = random_sample(exposure);
                send_sample(p.sample, tonemap_code(p.sample, exposure));
                // Let the pipeline run dry once in the middle of a phase.
                if (ph == 2 && n == HOLD_AT_ITEM)
                begin
                    sample_ch.valid <= 1'b0;
                    wait_drained();
                end
            end
            sample_ch.valid <= 1'b0;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_codes.size() != 0)
        begin
            $display("%0t: %0d display codes never arrived", $time, pending_codes.size());
        end
        if (failures == 0 && pending_codes.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ftgq_pkg.sv
hw/rtl/ftgq_channels.sv
hw/rtl/ftgq_divider.sv
hw/rtl/ftgq_gamma.sv
hw/rtl/filmic_tonemap_gamma_quantize_unit.sv
hw/rtl/ftgq_checker.sv
tb/tb_top.sv
